// ===== src/tlik_pkg.sv =====
// Shared widths, reset values, register indexes and the arctangent table
// of the two-link arm inverse kinematics block. No dependencies.
package tlik_pkg;

  localparam int CFG_W        = 20;
  localparam int IN_W         = 21;
  localparam int ANG_W        = 16;
  localparam int ND_W         = 46;
  localparam int C_W          = 54;
  localparam int SQ_W         = C_W / 2;
  localparam int REM_W        = SQ_W + 3;
  localparam int M_W          = 45;
  localparam int XY_W         = 49;
  localparam int ACC_W        = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int FRONT_LAT    = 5;
  localparam int LANE_LAT     = CORDIC_STEPS + 4;

  localparam logic [CFG_W-1:0] LINK_ONE_RESET = 20'd11469;
  localparam logic [CFG_W-1:0] LINK_TWO_RESET = 20'd27525;
  localparam logic [CFG_W-1:0] OFFSET_RESET   = 20'd1638;

  typedef enum logic [1:0] {
    REG_LINK_ONE = 2'd0,
    REG_LINK_TWO = 2'd1,
    REG_OFFSET   = 2'd2
  } cfg_reg_t;

  // Arctangent of 2^-i in units of pi/2^31.
  localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
    32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
    32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41, 32'sd20,
    32'sd10, 32'sd5, 32'sd3, 32'sd1
  };

  typedef struct packed {
    logic                   reach;
    logic signed [ND_W-1:0] base1;
    logic signed [ND_W-1:0] base2;
    logic signed [ND_W-1:0] d1;
    logic signed [ND_W-1:0] d2;
  } side_t;

endpackage

// ===== src/tlik_front.sv =====
// Front end: products, Q16 rounding, discriminant, numerator bases and
// denominators over five register stages. Depends on tlik_pkg.
module tlik_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [tlik_pkg::IN_W-1:0]  x,
  input  logic signed [tlik_pkg::IN_W-1:0]  z,
  input  logic [tlik_pkg::CFG_W-1:0]    l1,
  input  logic [tlik_pkg::CFG_W-1:0]    l2,
  input  logic [tlik_pkg::CFG_W-1:0]    x1,
  output logic                          out_valid,
  output logic [tlik_pkg::C_W-1:0]      c,
  output tlik_pkg::side_t               side
);
  import tlik_pkg::*;

  logic [FRONT_LAT-1:0] v_r;

  logic signed [20:0] l1s, l2s, x1s;
  logic signed [21:0] xa, zb, dl;
  assign l1s = $signed({1'b0, l1});
  assign l2s = $signed({1'b0, l2});
  assign x1s = $signed({1'b0, x1});
  assign xa  = {x[20], x} + {x1s[20], x1s};
  assign zb  = {z[20], z} + {l1s[20], l1s};
  assign dl  = {l1s[20], l1s} - {l2s[20], l2s};

  // Stage 1: products
  logic signed [41:0] xx_r, zz_r, l1l1_r, x1x1_r, l2l2_r, l1x_r, x1z_r, l2x1_r;
  logic signed [43:0] ax_r, bz_r, dl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r   <= x * x;
      zz_r   <= z * z;
      l1l1_r <= l1s * l1s;
      x1x1_r <= x1s * x1s;
      l2l2_r <= l2s * l2s;
      l1x_r  <= l1s * x;
      x1z_r  <= x1s * z;
      l2x1_r <= l2s * x1s;
      ax_r   <= xa * xa;
      bz_r   <= zb * zb;
      dl_r   <= dl * dl;
    end
  end

  // Stage 2: sums and rounding to Q16
  logic signed [42:0] r2_32, lsum;
  logic signed [27:0] r2_nxt, lq_nxt, l2q_nxt;
  logic signed [27:0] r2_r, lq_r, l2q_r;
  side_t side2_nxt, side2_r, side3_r, side4_r, side5_nxt, side5_r;

  always_comb begin
    r2_32   = 43'(xx_r) + 43'(zz_r);
    lsum    = 43'(l1l1_r) + 43'(x1x1_r);
    r2_nxt  = 28'((r2_32 + 43'sd32768) >>> 16);
    lq_nxt  = 28'((lsum + 43'sd32768) >>> 16);
    l2q_nxt = 28'((43'(l2l2_r) + 43'sd32768) >>> 16);
    side2_nxt.reach = 1'b0;
    side2_nxt.d1    = 46'(ax_r) + 46'(bz_r) - 46'(l2l2_r);
    side2_nxt.d2    = 46'(dl_r) + 46'(x1x1_r) - 46'(xx_r) - 46'(zz_r);
    side2_nxt.base1 = (46'(l1x_r) - 46'(x1z_r)) <<< 1;
    side2_nxt.base2 = 46'(l2x1_r) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r    <= r2_nxt;
      lq_r    <= lq_nxt;
      l2q_r   <= l2q_nxt;
      side2_r <= side2_nxt;
    end
  end

  // Stage 3: s and the product of the rounded squares
  logic signed [27:0] s_r;
  logic signed [55:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= lq_r + l2q_r - r2_r;
      p_r     <= lq_r * l2q_r;
      side3_r <= side2_r;
    end
  end

  // Stage 4: square of s
  logic signed [55:0] ss_r, p4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ss_r    <= s_r * s_r;
      p4_r    <= p_r <<< 2;
      side4_r <= side3_r;
    end
  end

  // Stage 5: discriminant and reachability
  logic signed [55:0] cd;
  logic [C_W-1:0]     c_nxt, c_r;

  always_comb begin
    cd              = p4_r - ss_r;
    side5_nxt       = side4_r;
    side5_nxt.reach = ~cd[55];
    c_nxt           = cd[55] ? '0 : cd[C_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r     <= c_nxt;
      side5_r <= side5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FRONT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = v_r[FRONT_LAT-1];
  assign c         = c_r;
  assign side      = side5_r;

endmodule

// ===== src/tlik_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage, with
// the side payload carried alongside. Depends on tlik_pkg.
module tlik_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tlik_pkg::C_W-1:0]   c,
  input  tlik_pkg::side_t            side_in,
  output logic                       out_valid,
  output logic [tlik_pkg::SQ_W-1:0]  root,
  output tlik_pkg::side_t            side_out
);
  import tlik_pkg::*;

  logic [SQ_W-1:0]  v_r;
  logic [REM_W-1:0] rem_r  [SQ_W];
  logic [SQ_W-1:0]  q_r    [SQ_W];
  logic [C_W-1:0]   c_r    [SQ_W];
  side_t            side_r [SQ_W];

  for (genvar j = 0; j < SQ_W; j++) begin : g_step
    logic [REM_W-1:0] rem_in, rem_sh, t;
    logic [SQ_W-1:0]  q_in;
    logic [C_W-1:0]   c_in;
    side_t            s_in;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign c_in   = c;
      assign s_in   = side_in;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign c_in   = c_r[j-1];
      assign s_in   = side_r[j-1];
    end

    // Bring down the next two radicand bits and try the trial subtrahend.
    assign rem_sh = {rem_in[REM_W-3:0], c_in[C_W-1-2*j -: 2]};
    assign t      = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= t) begin
          rem_r[j] <= rem_sh - t;
          q_r[j]   <= {q_in[SQ_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= rem_sh;
          q_r[j]   <= {q_in[SQ_W-2:0], 1'b0};
        end
        c_r[j]    <= c_in;
        side_r[j] <= s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ_W-2:0], in_valid};
    end
  end

  assign out_valid = v_r[SQ_W-1];
  assign root      = q_r[SQ_W-1];
  assign side_out  = side_r[SQ_W-1];

endmodule

// ===== src/tlik_cordic.sv =====
// One angle lane: sign folding, normalising shift, 30 vectoring CORDIC
// stages and rounding to a 16-bit binary angle of twice the arctangent.
// Depends on tlik_pkg.
module tlik_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tlik_pkg::ND_W-1:0]  num,
  input  logic signed [tlik_pkg::ND_W-1:0]  den,
  output logic [tlik_pkg::ANG_W-1:0]        angle
);
  import tlik_pkg::*;

  // Stage 0: fold the sign of the denominator into the numerator.
  logic signed [ND_W-1:0] ax, ay, my;
  logic [ND_W-1:0]        mx;
  logic signed [XY_W-1:0] x0_r, y0_r;
  logic [M_W-1:0]         m0_r;
  logic                   dz0_r, yz0_r;

  always_comb begin
    ax = den[ND_W-1] ? -den : den;
    ay = den[ND_W-1] ? -num : num;
    my = ay[ND_W-1] ? -ay : ay;
    mx = ($unsigned(my) > $unsigned(ax)) ? $unsigned(my) : $unsigned(ax);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= XY_W'(ax);
      y0_r  <= XY_W'(ay);
      m0_r  <= mx[M_W-1:0];
      dz0_r <= (den == '0);
      yz0_r <= (ay == '0);
    end
  end

  // Stages 1 and 2: shift left until the larger magnitude reaches 2^44.
  logic signed [XY_W-1:0] x1n, y1n, x2n, y2n, x1_r, y1_r, xs_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] ys_r [CORDIC_STEPS+1];
  logic [M_W-1:0]         m1n, m1_r;
  logic                   dz1_r, yz1_r;
  logic                   dz_r [CORDIC_STEPS+1];
  logic                   yz_r [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] a_r [CORDIC_STEPS+1];

  always_comb begin
    x1n = x0_r;
    y1n = y0_r;
    m1n = m0_r;
    if (m1n[M_W-1:13] == '0) begin
      x1n = x1n <<< 32; y1n = y1n <<< 32; m1n = m1n << 32;
    end
    if (m1n[M_W-1:29] == '0) begin
      x1n = x1n <<< 16; y1n = y1n <<< 16; m1n = m1n << 16;
    end
    if (m1n[M_W-1:37] == '0) begin
      x1n = x1n <<< 8; y1n = y1n <<< 8; m1n = m1n << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x1n;
      y1_r  <= y1n;
      m1_r  <= m1n;
      dz1_r <= dz0_r;
      yz1_r <= yz0_r;
    end
  end

  always_comb begin
    logic [M_W-1:0] mt;
    x2n = x1_r;
    y2n = y1_r;
    mt  = m1_r;
    if (mt[M_W-1:41] == '0) begin
      x2n = x2n <<< 4; y2n = y2n <<< 4; mt = mt << 4;
    end
    if (mt[M_W-1:43] == '0) begin
      x2n = x2n <<< 2; y2n = y2n <<< 2; mt = mt << 2;
    end
    if (mt[M_W-1] == 1'b0) begin
      x2n = x2n <<< 1; y2n = y2n <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r[0] <= x2n;
      ys_r[0] <= y2n;
      a_r[0]  <= '0;
      dz_r[0] <= dz1_r;
      yz_r[0] <= yz1_r;
    end
  end

  // Vectoring iterations: drive y towards zero and sum the rotations.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [XY_W-1:0] dxs, dys;
    logic                   pos;
    assign dxs = xs_r[i] >>> i;
    assign dys = ys_r[i] >>> i;
    assign pos = ~ys_r[i][XY_W-1] && (ys_r[i] != '0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          xs_r[i+1] <= xs_r[i] + dys;
          ys_r[i+1] <= ys_r[i] - dxs;
          a_r[i+1]  <= a_r[i] + ATAN_TAB[i];
        end else begin
          xs_r[i+1] <= xs_r[i] - dys;
          ys_r[i+1] <= ys_r[i] + dxs;
          a_r[i+1]  <= a_r[i] - ATAN_TAB[i];
        end
        dz_r[i+1] <= dz_r[i];
        yz_r[i+1] <= yz_r[i];
      end
    end
  end

  // Rounding: half up to pi/32768 and wrap to 16 bits.
  logic signed [ACC_W:0] ar;
  logic [ANG_W-1:0]      ang_r;
  assign ar = (ACC_W+1)'(a_r[CORDIC_STEPS]) + (ACC_W+1)'(16384);

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_r[CORDIC_STEPS]) begin
        ang_r <= {1'b1, {(ANG_W-1){1'b0}}};
      end else if (yz_r[CORDIC_STEPS]) begin
        ang_r <= '0;
      end else begin
        ang_r <= ar[ACC_W-2 -: ANG_W];
      end
    end
  end

  assign angle = ang_r;

endmodule

// ===== src/two_link_inverse_kinematics.sv =====
// Top level of the two-link arm inverse kinematics block: configuration
// registers, front end, square root, four angle lanes and output skid.
// Depends on tlik_pkg, tlik_front, tlik_isqrt and tlik_cordic.

// Each target (x, z) is answered by one result carrying both elbow
// solutions. One target is accepted every clock cycle unless the skid
// entry is full; an accepted input passes 5 front-end stages, 27 square
// root stages, one numerator stage, 34 CORDIC lane stages and the output
// register. The whole pipeline moves on one enable, and a skid register
// after it lets a further result drain while the output is stalled.
// Link lengths and offset should be written only while no target is in
// flight.
module two_link_inverse_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_x [20:0], target_z [41:21], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // upper_first_angle, upper_second_angle,
                                  // lower_first_angle, lower_second_angle
  output logic [0:0]  out_tuser,  // reachable
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [tlik_pkg::CFG_W-1:0] cfg_wdata
);
  import tlik_pkg::*;

  logic [CFG_W-1:0] l1_r, l2_r, x1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= LINK_ONE_RESET;
      l2_r <= LINK_TWO_RESET;
      x1_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_ONE: l1_r <= cfg_wdata;
        REG_LINK_TWO: l2_r <= cfg_wdata;
        REG_OFFSET:   x1_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r;
  assign en        = ~skid_v_r;
  assign in_tready = en;

  logic            f_valid;
  logic [C_W-1:0]  f_c;
  side_t           f_side;

  tlik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .x         ($signed(in_tdata[20:0])),
    .z         ($signed(in_tdata[41:21])),
    .l1        (l1_r),
    .l2        (l2_r),
    .x1        (x1_r),
    .out_valid (f_valid),
    .c         (f_c),
    .side      (f_side)
  );

  logic            q_valid;
  logic [SQ_W-1:0] q_root;
  side_t           q_side;

  tlik_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .c         (f_c),
    .side_in   (f_side),
    .out_valid (q_valid),
    .root      (q_root),
    .side_out  (q_side)
  );

  // Numerators of the four half-angle tangents.
  logic signed [ND_W-1:0] sq32;
  logic signed [ND_W-1:0] n_r [4];
  logic signed [ND_W-1:0] d1_r, d2_r;
  logic                   nv_r, nreach_r;
  assign sq32 = $signed({{(ND_W-SQ_W-16){1'b0}}, q_root, 16'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= q_side.base1 - sq32;
      n_r[1]   <= -(q_side.base2 + sq32);
      n_r[2]   <= q_side.base1 + sq32;
      n_r[3]   <= sq32 - q_side.base2;
      d1_r     <= q_side.d1;
      d2_r     <= q_side.d2;
      nreach_r <= q_side.reach;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= q_valid;
    end
  end

  logic [ANG_W-1:0] ang [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    tlik_cordic u_lane (
      .clk   (clk),
      .en    (en),
      .num   (n_r[k]),
      .den   (((k % 2) == 1) ? d2_r : d1_r),
      .angle (ang[k])
    );
  end

  // Valid and reachability travel beside the lanes.
  logic [LANE_LAT-1:0] lv_r, lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (en) begin
      lv_r <= {lv_r[LANE_LAT-2:0], nv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lr_r <= {lr_r[LANE_LAT-2:0], nreach_r};
    end
  end

  logic        p_valid, p_reach;
  logic [63:0] p_data;
  assign p_valid = lv_r[LANE_LAT-1];
  assign p_reach = lr_r[LANE_LAT-1];
  assign p_data  = p_reach ? {ang[3], ang[2], ang[1], ang[0]} : '0;

  // Output register with one skid entry behind it.
  logic        out_v_r, skid_reach_r, out_reach_r, take;
  logic [63:0] out_data_r, skid_data_r;
  assign take = ~out_v_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      out_v_r  <= skid_v_r | p_valid;
      skid_v_r <= 1'b0;
    end else if (en && p_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r  <= skid_v_r ? skid_data_r : p_data;
      out_reach_r <= skid_v_r ? skid_reach_r : p_reach;
    end else if (en) begin
      skid_data_r  <= p_data;
      skid_reach_r <= p_reach;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_reach_r;

endmodule

// ===== src/tlik_checker.sv =====
// Port-level checks for the two-link arm inverse kinematics block, bound
// to the top level. Depends on two_link_inverse_kinematics.
module tlik_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled transaction on the result side stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  // An unreachable target carries all angles zero.
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0)
    else $error("unreachable target with nonzero angles");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result offered straight after reset");

endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/tb_two_link_inverse_kinematics.sv =====
// Testbench for the two-link arm inverse kinematics block: a directed table, then random
// targets under several link settings and flow-control patterns, each checked against
// a set answer or a behavioural fixed-point model. Depends on tlik_pkg and the RTL.
`timescale 1ns / 100ps

module tb_two_link_inverse_kinematics;
  import tlik_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic        reach;
    logic [15:0] upper_first;
    logic [15:0] upper_second;
    logic [15:0] lower_first;
    logic [15:0] lower_second;
  } arm_solution_t;

  typedef struct {
    logic [CFG_W-1:0]       l1;
    logic [CFG_W-1:0]       l2;
    logic [CFG_W-1:0]       x1;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] z;
    bit                     fixed;
    arm_solution_t          sol;
  } target_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  logic [CFG_W-1:0] link_one;
  logic [CFG_W-1:0] link_two;
  logic [CFG_W-1:0] offset;

  arm_solution_t expected_solutions[$];
  target_row_t directed_rows[$];
  int error_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  two_link_inverse_kinematics uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Twice the arctangent of num/den as a binary angle, via vectoring CORDIC.
  function automatic logic [15:0] double_atan_bam(longint num, longint den);
    longint x;
    longint y;
    longint a;
    longint dx;
    longint dy;
    longint unsigned m;
    int i;
    if (den == 0) return 16'h8000;
    x = den < 0 ? -den : den;
    y = den < 0 ? -num : num;
    if (y == 0) return 16'h0000;
    m = y < 0 ? -y : y;
    if (longint'(m) < x) m = x;
    while (m < (64'd1 << 44)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    a = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy;
        y = y - dx;
        a = a + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dy;
        y = y + dx;
        a = a - longint'(ATAN_TAB[i]);
      end
    end
    return 16'((a + 16384) >>> 15);
  endfunction

  function automatic arm_solution_t solve_arm(logic signed [IN_W-1:0] tx,
                                              logic signed [IN_W-1:0] tz);
    arm_solution_t sol;
    longint x;
    longint z;
    longint l1;
    longint l2;
    longint x1;
    longint r2_full;
    longint r2;
    longint lq;
    longint l2q;
    longint s;
    longint c;
    longint sq;
    longint base1;
    longint base2;
    longint d1;
    longint d2;
    x = tx;
    z = tz;
    l1 = longint'(link_one);
    l2 = longint'(link_two);
    x1 = longint'(offset);
    sol = '0;
    r2_full = x * x + z * z;
    r2 = (r2_full + 32768) >>> 16;
    lq = (l1 * l1 + x1 * x1 + 32768) >>> 16;
    l2q = (l2 * l2 + 32768) >>> 16;
    s = lq + l2q - r2;
    c = 4 * lq * l2q - s * s;
    if (c < 0) return sol;
    sq = longint'(int_sqrt(c)) << 16;
    base1 = 2 * l1 * x - 2 * x1 * z;
    base2 = 2 * l2 * x1;
    d1 = (x + x1) * (x + x1) + (z + l1) * (z + l1) - l2 * l2;
    d2 = (l1 - l2) * (l1 - l2) + x1 * x1 - r2_full;
    sol.reach = 1'b1;
    sol.upper_first = double_atan_bam(base1 - sq, d1);
    sol.upper_second = double_atan_bam(-(base2 + sq), d2);
    sol.lower_first = double_atan_bam(base1 + sq, d1);
    sol.lower_second = double_atan_bam(sq - base2, d2);
    return sol;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field,
             $signed(got), $signed(want));
    error_count++;
  endtask

  task automatic fail_run(string why);
    $display("%0t: %s", $time, why);
    $display("tb_two_link_inverse_kinematics: errors");
    $finish;
  endtask

  // Result side: check every transaction, randomise tready, watch for hangs.
  always @(posedge clk) begin
    arm_solution_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_solutions.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          error_count++;
        end else begin
          want = expected_solutions.pop_front();
          if (out_tuser[0] !== want.reach)
            report_mismatch("reachable", 16'(out_tuser[0]), 16'(want.reach));
          if (out_tdata[15:0] !== want.upper_first)
            report_mismatch("upper_first_angle", out_tdata[15:0], want.upper_first);
          if (out_tdata[31:16] !== want.upper_second)
            report_mismatch("upper_second_angle", out_tdata[31:16], want.upper_second);
          if (out_tdata[47:32] !== want.lower_first)
            report_mismatch("lower_first_angle", out_tdata[47:32], want.lower_first);
          if (out_tdata[63:48] !== want.lower_second)
            report_mismatch("lower_second_angle", out_tdata[63:48], want.lower_second);
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) fail_run("watchdog expired");
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_target(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] z,
                             bit fixed, arm_solution_t sol);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, z, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_solutions.push_back(fixed ? sol : solve_arm(x, z));
  endtask

  // Registers are only written once the pipeline has emptied.
  task automatic write_links(logic [CFG_W-1:0] l1, logic [CFG_W-1:0] l2,
                             logic [CFG_W-1:0] x1);
    in_tvalid <= 1'b0;
    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LINK_ONE;
    cfg_wdata <= l1;
    @(posedge clk);
    cfg_index <= REG_LINK_TWO;
    cfg_wdata <= l2;
    @(posedge clk);
    cfg_index <= REG_OFFSET;
    cfg_wdata <= x1;
    @(posedge clk);
    // The spare index must leave all three registers untouched.
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    link_one = l1;
    link_two = l2;
    offset = x1;
  endtask

  task automatic add_row(logic [CFG_W-1:0] l1, logic [CFG_W-1:0] l2,
                         logic [CFG_W-1:0] x1, longint x, longint z,
                         bit fixed, arm_solution_t sol);
    target_row_t row;
    row.l1 = l1;
    row.l2 = l2;
    row.x1 = x1;
    row.x = IN_W'(x);
    row.z = IN_W'(z);
    row.fixed = fixed;
    row.sol = sol;
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [IN_W-1:0] random_coord(longint span);
    longint v;
    if ($urandom_range(99) < 30) return IN_W'($urandom);
    v = longint'($urandom_range(0, 32'(2 * span))) - span;
    if (v > 1048575) v = 1048575;
    if (v < -1048576) v = -1048576;
    return IN_W'(v);
  endfunction

  initial begin
    arm_solution_t none;
    arm_solution_t all_pi;
    arm_solution_t level;
    logic [CFG_W-1:0] mx;
    longint span;
    int p;
    int n;
    none = '0;
    all_pi = '{1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    level = '{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
    mx = '1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LINK_ONE;
    cfg_wdata = '0;
    error_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    link_one = LINK_ONE_RESET;
    link_two = LINK_TWO_RESET;
    offset = OFFSET_RESET;

    // Reset values first, then zero links (degenerate arm), the largest links and mixed largest and zero links.
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 1048575, 1048575, 1, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, -1048576, -1048576, 1, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 0, 0, 1, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 1048575, 0, 1, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 0, -1048576, 1, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 20000, 10000, 0, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, -20000, 5000, 0, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 0, 30000, 0, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 30000, 0, 0, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 38994, 1638, 0, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, -1638, -38994, 0, none);
    add_row(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET, 16056, -11469, 0, none);
    add_row(0, 0, 0, 0, 0, 1, all_pi);
    add_row(0, 0, 0, 1, 0, 1, level);
    add_row(0, 0, 0, 0, -1, 0, none);
    add_row(0, 0, 0, 1048575, 1048575, 1, none);
    add_row(mx, mx, mx, 0, 0, 0, none);
    add_row(mx, mx, mx, 1048575, -1048576, 0, none);
    add_row(mx, mx, mx, -1048576, 1048575, 0, none);
    add_row(mx, mx, mx, 1048575, 1048575, 0, none);
    add_row(mx, 0, 0, 0, 1048575, 0, none);
    add_row(0, mx, 0, -1048576, 0, 0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].l1 != link_one || directed_rows[i].l2 != link_two ||
          directed_rows[i].x1 != offset)
        write_links(directed_rows[i].l1, directed_rows[i].l2, directed_rows[i].x1);
      send_target(directed_rows[i].x, directed_rows[i].z, directed_rows[i].fixed,
                  directed_rows[i].sol);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_links(LINK_ONE_RESET, LINK_TWO_RESET, OFFSET_RESET);
        2: write_links(mx, mx, mx);
        3: write_links(0, 0, 0);
        4: write_links(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        5: write_links(mx, CFG_W'($urandom_range(0, 60000)), CFG_W'($urandom_range(0, 5000)));
        default: write_links(CFG_W'($urandom_range(1000, 60000)),
                             CFG_W'($urandom_range(1000, 60000)),
                             CFG_W'($urandom_range(0, 8000)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      span = longint'(link_one) + longint'(link_two) + longint'(offset);
      if (span > 1048575) span = 1048575;
      if (span < 16) span = 16;
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        send_target(random_coord(span), random_coord(span), 0, none);
    end

    in_tvalid <= 1'b0;
    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_two_link_inverse_kinematics: clean");
    end else begin
      $display("tb_two_link_inverse_kinematics: errors");
    end
    $finish;
  end

endmodule
